// ===== design/ect_pkg.sv =====
// ----------------------------------------------------------------------------
// Ear clipping triangulator package
// Shared defaults and fixed field widths of the triangulator.
// ----------------------------------------------------------------------------
package ect_pkg;

	// Default capacity of the vertex store.
	localparam int MAX_VERTICES_DEF = 64;
	// Default coordinate width in bits.
	localparam int COORD_BITS_DEF = 24;
	// Width of a vertex index field on the result channel.
	localparam int CORNER_BITS = 6;

endpackage

// ===== design/ear_clipping_triangulator_top.sv =====
// ----------------------------------------------------------------------------
// Ear clipping triangulator
// Stores a polygon vertex by vertex and clips ears with one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: vertices arrive on the input channel (in_valid, in_ready) with
// vertex_x, vertex_y and last_vertex. Each transaction without the last
// marker stores one vertex. The transaction with last_vertex set
// stores its vertex and starts ear clipping; in_ready stays low until the
// polygon is finished. Vertices beyond MAX_VERTICES are dropped and flagged.
// Results leave on the output channel (out_valid, out_ready), one transaction
// per triangle, the final one with last_result set and the status flags.
// With no triangle a single status transaction is sent.
// A candidate corner is fetched with a ring read and a coordinate read for
// each of its three vertices, then tested for convexity with two products;
// every other ring vertex it is tested against needs one ring read, one
// coordinate read and six products through the single multiplier. The
// search is bounded by the multiplier and the one-port coordinate store.
// Removing an ear tip shifts the ring entry by entry, one read state and
// one write state per entry.
// Reset clears all control state; no clearing pass runs over the stores.
// A stalled receiver holds the result register; one found triangle waits in
// a pending register and the search halts until the result register frees.
// ----------------------------------------------------------------------------
module ear_clipping_triangulator_top #(
	parameter int MAX_VERTICES = ect_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = ect_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_BITS-1:0]       vertex_x,
	input  logic signed [COORD_BITS-1:0]       vertex_y,
	input  logic                               last_vertex,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ect_pkg::CORNER_BITS-1:0]    corner_prev,
	output logic [ect_pkg::CORNER_BITS-1:0]    corner_ear,
	output logic [ect_pkg::CORNER_BITS-1:0]    corner_next,
	output logic                               has_triangle,
	output logic                               incomplete,
	output logic                               overflow,
	output logic                               last_result
);
	import ect_pkg::*;

	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam logic [CW-1:0] CAP = CW'(MAX_VERTICES);

	typedef enum logic [3:0] {
		S_LOAD, S_INIT, S_FR, S_FX, S_FS, S_MUL, S_ACC, S_JCHK,
		S_EMIT, S_RMR, S_RMW, S_DONE
	} state_t;

	state_t state_q;

	// Stores.
	logic signed [COORD_BITS-1:0] x_mem [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] y_mem [MAX_VERTICES];
	logic [IW-1:0] ring_mem [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] xr_q, yr_q;
	logic [IW-1:0] ring_q;

	// Control registers.
	logic [CW-1:0] loaded_q, rem_q, i_q, j_q, k_q;
	logic [1:0]    sel_q;
	logic [2:0]    t_q;
	logic          ovf_q, inc_q, neg_q, pos_q, pend_v_q, out_valid_q;

	// Corner and probe coordinates and indices.
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, px_q, py_q;
	logic [IW-1:0] ia_q, ib_q, ic_q;
	logic [IW-1:0] pa_q, pb_q, pc_q;
	logic signed [PW-1:0] prod_q, p_q;

	// Result register.
	logic [IW-1:0] oa_q, ob_q, oc_q;
	logic          ohas_q, oinc_q, oovf_q, olast_q;

	logic [CW-1:0] pi_c, ni_c, fetch_c, rem_m1;
	logic [IW-1:0] ring_ra, ring_wa, ring_wd, xy_ra;
	logic          ring_we, in_fire, out_free, gt_c, lt_c;
	logic signed [DW-1:0] opa, opb;

	function automatic logic signed [DW-1:0] dif(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		dif = DW'(a) - DW'(b);
	endfunction

	assign in_ready = (state_q == S_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign rem_m1   = rem_q - CW'(1);

	// Ring neighbours of the current corner and the ring slot being fetched.
	always_comb begin
		pi_c = (i_q == '0) ? rem_m1 : i_q - CW'(1);
		ni_c = (i_q == rem_m1) ? '0 : i_q + CW'(1);
		case (sel_q)
			2'd0:    fetch_c = pi_c;
			2'd1:    fetch_c = i_q;
			2'd2:    fetch_c = ni_c;
			default: fetch_c = j_q;
		endcase
	end

	// Store addressing and ring writes.
	always_comb begin
		ring_ra = fetch_c[IW-1:0];
		if (state_q == S_RMR)
			ring_ra = IW'(k_q + CW'(1));
		xy_ra   = ring_q;
		ring_we = (state_q == S_INIT) || (state_q == S_RMW);
		ring_wa = k_q[IW-1:0];
		ring_wd = (state_q == S_INIT) ? k_q[IW-1:0] : ring_q;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (t_q)
			3'd0:    begin opa = dif(bx_q, ax_q); opb = dif(cy_q, ay_q); end
			3'd1:    begin opa = dif(by_q, ay_q); opb = dif(cx_q, ax_q); end
			3'd2:    begin opa = dif(px_q, cx_q); opb = dif(ay_q, cy_q); end
			3'd3:    begin opa = dif(ax_q, cx_q); opb = dif(py_q, cy_q); end
			3'd4:    begin opa = dif(px_q, ax_q); opb = dif(by_q, ay_q); end
			3'd5:    begin opa = dif(bx_q, ax_q); opb = dif(py_q, ay_q); end
			3'd6:    begin opa = dif(px_q, bx_q); opb = dif(cy_q, by_q); end
			default: begin opa = dif(cx_q, bx_q); opb = dif(py_q, by_q); end
		endcase
		gt_c = p_q > prod_q;
		lt_c = p_q < prod_q;
	end

	// Memories with registered reads.
	always_ff @(posedge clk) begin
		if (in_fire && (loaded_q < CAP)) begin
			x_mem[loaded_q[IW-1:0]] <= vertex_x;
			y_mem[loaded_q[IW-1:0]] <= vertex_y;
		end
		if (ring_we)
			ring_mem[ring_wa] <= ring_wd;
		ring_q <= ring_mem[ring_ra];
		xr_q   <= x_mem[xy_ra];
		yr_q   <= y_mem[xy_ra];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == S_MUL)
			prod_q <= opa * opb;
		if (state_q == S_ACC && !t_q[0])
			p_q <= prod_q;
		if (state_q == S_FS) begin
			case (sel_q)
				2'd0:    begin ax_q <= xr_q; ay_q <= yr_q; ia_q <= ring_q; end
				2'd1:    begin bx_q <= xr_q; by_q <= yr_q; ib_q <= ring_q; end
				2'd2:    begin cx_q <= xr_q; cy_q <= yr_q; ic_q <= ring_q; end
				default: begin px_q <= xr_q; py_q <= yr_q; end
			endcase
		end
	end

	// Sequencer, pending triangle and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			loaded_q    <= '0;
			rem_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			sel_q       <= '0;
			t_q         <= '0;
			ovf_q       <= 1'b0;
			inc_q       <= 1'b0;
			neg_q       <= 1'b0;
			pos_q       <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			pa_q        <= '0;
			pb_q        <= '0;
			pc_q        <= '0;
			oa_q        <= '0;
			ob_q        <= '0;
			oc_q        <= '0;
			ohas_q      <= 1'b0;
			oinc_q      <= 1'b0;
			oovf_q      <= 1'b0;
			olast_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (loaded_q < CAP)
							loaded_q <= loaded_q + CW'(1);
						else
							ovf_q <= 1'b1;
						if (last_vertex) begin
							inc_q <= 1'b0;
							k_q   <= '0;
							if ((loaded_q < CAP ? loaded_q + CW'(1) : loaded_q) >= CW'(3)) begin
								rem_q   <= (loaded_q < CAP) ? loaded_q + CW'(1) : loaded_q;
								state_q <= S_INIT;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				// Fill the ring with the identity order.
				S_INIT: begin
					if (k_q == rem_m1) begin
						i_q     <= '0;
						sel_q   <= '0;
						state_q <= S_FR;
					end
					k_q <= k_q + CW'(1);
				end
				S_FR: state_q <= S_FX;
				S_FX: state_q <= S_FS;
				S_FS: begin
					if (sel_q == 2'd3) begin
						t_q     <= 3'd2;
						neg_q   <= 1'b0;
						pos_q   <= 1'b0;
						state_q <= S_MUL;
					end else if (sel_q == 2'd2) begin
						t_q     <= 3'd0;
						state_q <= S_MUL;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= S_FR;
					end
				end
				S_MUL: state_q <= S_ACC;
				// Keep the first product or compare it with the second.
				S_ACC: begin
					if (!t_q[0]) begin
						t_q     <= t_q + 3'd1;
						state_q <= S_MUL;
					end else if (t_q == 3'd1) begin
						if (gt_c) begin
							j_q     <= '0;
							state_q <= S_JCHK;
						end else if (i_q == rem_m1) begin
							inc_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q + CW'(1);
							sel_q   <= '0;
							state_q <= S_FR;
						end
					end else if (t_q != 3'd7) begin
						neg_q   <= neg_q | lt_c;
						pos_q   <= pos_q | gt_c;
						t_q     <= t_q + 3'd1;
						state_q <= S_MUL;
					end else if (!((neg_q | lt_c) && (pos_q | gt_c))) begin
						// The probe lies inside or on the triangle: try the next corner.
						if (i_q == rem_m1) begin
							inc_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							i_q     <= i_q + CW'(1);
							sel_q   <= '0;
							state_q <= S_FR;
						end
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= S_JCHK;
					end
				end
				// Pick the next probe vertex, skipping the corner's own three.
				S_JCHK: begin
					if (j_q == rem_q) begin
						state_q <= S_EMIT;
					end else if (j_q == pi_c || j_q == i_q || j_q == ni_c) begin
						j_q <= j_q + CW'(1);
					end else begin
						sel_q   <= 2'd3;
						state_q <= S_FR;
					end
				end
				// Park the new ear; the older one goes to the result register.
				S_EMIT: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							oa_q        <= pa_q;
							ob_q        <= pb_q;
							oc_q        <= pc_q;
							ohas_q      <= 1'b1;
							oinc_q      <= 1'b0;
							oovf_q      <= 1'b0;
							olast_q     <= 1'b0;
							out_valid_q <= 1'b1;
						end
						pa_q     <= ia_q;
						pb_q     <= ib_q;
						pc_q     <= ic_q;
						pend_v_q <= 1'b1;
						k_q      <= i_q;
						state_q  <= S_RMR;
					end
				end
				// Shift the ring down over the removed ear tip.
				S_RMR: begin
					if (k_q + CW'(1) == rem_q) begin
						rem_q <= rem_m1;
						if (rem_m1 > CW'(2)) begin
							i_q     <= '0;
							sel_q   <= '0;
							state_q <= S_FR;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_RMW;
					end
				end
				S_RMW: begin
					k_q     <= k_q + CW'(1);
					state_q <= S_RMR;
				end
				// Final transaction with status; clear for the next polygon.
				S_DONE: begin
					if (out_free) begin
						oa_q        <= pend_v_q ? pa_q : '0;
						ob_q        <= pend_v_q ? pb_q : '0;
						oc_q        <= pend_v_q ? pc_q : '0;
						ohas_q      <= pend_v_q;
						oinc_q      <= inc_q;
						oovf_q      <= ovf_q;
						olast_q     <= 1'b1;
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						loaded_q    <= '0;
						rem_q       <= '0;
						ovf_q       <= 1'b0;
						inc_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign corner_prev  = CORNER_BITS'(oa_q);
	assign corner_ear   = CORNER_BITS'(ob_q);
	assign corner_next  = CORNER_BITS'(oc_q);
	assign has_triangle = ohas_q;
	assign incomplete   = oinc_q;
	assign overflow     = oovf_q;
	assign last_result  = olast_q;

	// A status-only transaction is always the final one.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_triangle |-> last_result)
		else $error("status transaction without last marker");

	// Flags appear only on the final transaction.
	a_flags_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> !incomplete && !overflow)
		else $error("status flags on a non-final transaction");

	// No triangle is left pending while vertices are loaded.
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> !pend_v_q)
		else $error("pending triangle left over after a polygon");

	// The ring never holds more vertices than were loaded.
	a_ring_size: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= loaded_q)
		else $error("ring larger than the loaded polygon");

endmodule

// ===== verif/ear_clipping_triangulator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ear clipping triangulator testbench
// Sends polygons vertex by vertex and compares every triangle and status
// transaction against a behavioral ear clipping predictor kept in the bench.
// ----------------------------------------------------------------------------
module ear_clipping_triangulator_top_tb;

	localparam int NV = ect_pkg::MAX_VERTICES_DEF;
	localparam int CB = ect_pkg::COORD_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000000;

	typedef struct packed {
		logic [5:0] prev;
		logic [5:0] ear;
		logic [5:0] nxt;
		logic       tri_ok;
		logic       incomp;
		logic       ovf;
		logic       last;
	} tri_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [CB-1:0] vertex_x;
	logic signed [CB-1:0] vertex_y;
	logic                 last_vertex;
	logic                 out_valid;
	logic                 out_ready;
	logic [5:0]           corner_prev;
	logic [5:0]           corner_ear;
	logic [5:0]           corner_next;
	logic                 has_triangle;
	logic                 incomplete;
	logic                 overflow;
	logic                 last_result;

	ear_clipping_triangulator_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.corner_prev(corner_prev), .corner_ear(corner_ear),
		.corner_next(corner_next), .has_triangle(has_triangle),
		.incomplete(incomplete), .overflow(overflow), .last_result(last_result)
	);

	// Predictor state: one polygon being collected.
	longint    poly_x [NV];
	longint    poly_y [NV];
	int        ring [NV];
	int        loaded;
	int        ring_len;
	bit        dropped;
	tri_item_t expected_tris[$];

	int  mismatches;
	int  watchdog;
	bit  sender_idle_on;
	bit  receiver_idle_on;
	int  hold_cycles;

	// Clock: period 4 ns.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Sign of a*b - c*d, exact.
	function automatic int cross_sign(longint a, longint b, longint c, longint d);
		longint p;
		longint q;
		p = a * b;
		q = c * d;
		return (p > q) ? 1 : ((p < q) ? -1 : 0);
	endfunction

	function automatic bit covers_point(int p, int a, int b, int c);
		int  s1;
		int  s2;
		int  s3;
		bit  neg;
		bit  pos;
		s1 = cross_sign(poly_x[p] - poly_x[c], poly_y[a] - poly_y[c],
			poly_x[a] - poly_x[c], poly_y[p] - poly_y[c]);
		s2 = cross_sign(poly_x[p] - poly_x[a], poly_y[b] - poly_y[a],
			poly_x[b] - poly_x[a], poly_y[p] - poly_y[a]);
		s3 = cross_sign(poly_x[p] - poly_x[b], poly_y[c] - poly_y[b],
			poly_x[c] - poly_x[b], poly_y[p] - poly_y[b]);
		neg = (s1 < 0) || (s2 < 0) || (s3 < 0);
		pos = (s1 > 0) || (s2 > 0) || (s3 > 0);
		return !(neg && pos);
	endfunction

	// Find and remove the first ear of the ring; returns 0 if none exists.
	function automatic bit clip_first_ear(output tri_item_t t);
		int  n;
		int  pi;
		int  ni;
		int  a;
		int  b;
		int  c;
		bit  blocked;
		n = ring_len;
		t = '0;
		for (int i = 0; i < n; i++) begin
			pi = (i + n - 1) % n;
			ni = (i + 1) % n;
			a = ring[pi];
			b = ring[i];
			c = ring[ni];
			if (cross_sign(poly_x[b] - poly_x[a], poly_y[c] - poly_y[a],
				poly_y[b] - poly_y[a], poly_x[c] - poly_x[a]) <= 0)
				continue;
			blocked = 1'b0;
			for (int j = 0; j < n; j++) begin
				if (j == pi || j == i || j == ni)
					continue;
				if (covers_point(ring[j], a, b, c)) begin
					blocked = 1'b1;
					break;
				end
			end
			if (blocked)
				continue;
			t.prev = a[5:0];
			t.ear = b[5:0];
			t.nxt = c[5:0];
			t.tri_ok = 1'b1;
			for (int k = i; k < n - 1; k++)
				ring[k] = ring[k + 1];
			ring_len = n - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Apply one accepted vertex to the predictor.
	task automatic predict_vertex(input logic signed [CB-1:0] vx,
		input logic signed [CB-1:0] vy, input logic lst);
		tri_item_t t;
		tri_item_t batch[$];
		bit        incomp;
		incomp = 1'b0;
		if (loaded < NV) begin
			poly_x[loaded] = longint'(vx);
			poly_y[loaded] = longint'(vy);
			loaded++;
		end else begin
			dropped = 1'b1;
		end
		if (!lst)
			return;
		if (loaded >= 3) begin
			for (int k = 0; k < loaded; k++)
				ring[k] = k;
			ring_len = loaded;
			while (ring_len > 2) begin
				if (!clip_first_ear(t))
					break;
				batch.push_back(t);
			end
			incomp = ring_len > 2;
		end
		if (batch.size() == 0)
			batch.push_back('0);
		batch[batch.size() - 1].incomp = incomp;
		batch[batch.size() - 1].ovf = dropped;
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			expected_tris.push_back(batch[i]);
		loaded = 0;
		ring_len = 0;
		dropped = 1'b0;
	endtask

	// Send one vertex transaction with optional idle burst before it.
	// Valid stays high after acceptance until the next transaction or an idle
	// period takes it down at the same falling edge.
	task automatic send_vertex(input int vx, input int vy, input bit lst);
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= vx[CB-1:0];
		vertex_y <= vy[CB-1:0];
		last_vertex <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_vertex(vx[CB-1:0], vy[CB-1:0], lst);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_tris.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_polygon(input int xs[$], input int ys[$]);
		foreach (xs[i])
			send_vertex(xs[i], ys[i], i == xs.size() - 1);
	endtask

	// Receiver ready: random idle bursts or a long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
			hold_cycles <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		tri_item_t want;
		tri_item_t got;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				watchdog <= 0;
			else
				watchdog <= watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
			if (out_valid && out_ready) begin
				got = {corner_prev, corner_ear, corner_next, has_triangle,
					incomplete, overflow, last_result};
				if (expected_tris.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result transaction %p", got);
				end else begin
					want = expected_tris.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %p, actual %p", want, got);
					end
				end
			end
		end
	end

	task automatic test_small_polygons();
		send_polygon('{0}, '{0});
		send_polygon('{0, 10}, '{0, 10});
		send_polygon('{0, 100, 0}, '{0, 0, 100});
		send_polygon('{0, 0, 100}, '{0, 100, 0});
		send_polygon('{0, 10, 20}, '{0, 10, 20});
		send_polygon('{0, 100, 100, 0}, '{0, 0, 100, 100});
		// Concave arrow with a reflex corner.
		send_polygon('{0, 100, 50, 100, 0}, '{0, 0, 50, 100, 100});
	endtask

	task automatic test_coordinate_extremes();
		send_polygon('{-8388608, 8388607, 8388607, -8388608},
			'{-8388608, -8388608, 8388607, 8388607});
		send_polygon('{-8388608, 8388607, 0}, '{8388607, 8388607, -8388608});
		// Vertex on an edge of a candidate triangle blocks that ear.
		send_polygon('{0, 20, 10, 20, 0}, '{0, 0, 10, 20, 20});
		send_polygon('{-1, -1, -1}, '{-1, -1, -1});
	endtask

	task automatic test_overflow();
		for (int i = 0; i < NV + 2; i++)
			send_vertex(1000 * i, (i * i) % 777, 1'b0);
		send_vertex(5, 5, 1'b1);
		wait_results_drained();
	endtask

	// Random convex-ish star polygons with random noise vertices mixed in.
	task automatic test_random_polygons(input int count);
		int n;
		int r;
		int xs[$];
		int ys[$];
		real ang;
		for (int p = 0; p < count; p++) begin
			xs = {};
			ys = {};
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(3, 8);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					xs.push_back(int'($urandom));
					ys.push_back(int'($urandom));
				end else begin
					ang = 6.2831853 * i / n;
					r = $urandom_range(100, 4000000);
					xs.push_back(int'(r * $cos(ang)));
					ys.push_back(int'(r * $sin(ang)));
				end
			end
			send_polygon(xs, ys);
		end
	endtask

	task automatic test_backpressure();
		// The long hold-off is loaded at a rising edge, away from the receiver.
		@(posedge clk);
		hold_cycles = 400;
		@(negedge clk);
		send_polygon('{0, 100, 100, 50, 0}, '{0, 0, 100, 150, 100});
		send_polygon('{0, 100, 0}, '{0, 0, 100});
		wait_results_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		last_vertex = 1'b0;
		loaded = 0;
		ring_len = 0;
		dropped = 1'b0;
		mismatches = 0;
		watchdog = 0;
		hold_cycles = 0;
		sender_idle_on = 1'b1;
		receiver_idle_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_small_polygons();
		test_coordinate_extremes();
		wait_results_drained();
		test_backpressure();
		test_overflow();
		test_random_polygons(4);
		sender_idle_on = 1'b0;
		receiver_idle_on = 1'b0;
		test_random_polygons(3);
		wait_results_drained();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && expected_tris.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
